>>> design/slme_pkg.sv
// Package: shared types, constants and phase table for the line motion engine.
`timescale 1ns / 1ps
package slme_pkg;

  localparam int QueueDepthDef = 32;
  localparam int CoordBitsDef  = 17;

  // Engine modes
  localparam logic [2:0] MODE_OUT     = 3'd0;
  localparam logic [2:0] MODE_SEEK    = 3'd1;
  localparam logic [2:0] MODE_RELEASE = 3'd2;
  localparam logic [2:0] MODE_READY   = 3'd3;
  localparam logic [2:0] MODE_LINE    = 3'd4;

  // Actions
  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_MOVE     = 3'd1;
  localparam logic [2:0] ACT_DRAW     = 3'd2;
  localparam logic [2:0] ACT_SPEED    = 3'd3;
  localparam logic [2:0] ACT_PRESSURE = 3'd4;
  localparam logic [2:0] ACT_HOME     = 3'd5;
  localparam logic [2:0] ACT_ORIGIN   = 3'd6;

  // Queue entry kinds
  localparam logic [1:0] KIND_MOVE     = 2'd0;
  localparam logic [1:0] KIND_DRAW     = 2'd1;
  localparam logic [1:0] KIND_SPEED    = 2'd2;
  localparam logic [1:0] KIND_PRESSURE = 2'd3;

  // Config register indexes
  localparam logic [2:0] REG_MAX_X      = 3'd0;
  localparam logic [2:0] REG_MAX_Y      = 3'd1;
  localparam logic [2:0] REG_X_REACH    = 3'd2;
  localparam logic [2:0] REG_HOME_LEAD  = 3'd3;
  localparam logic [2:0] REG_MOTOR_OFF  = 3'd4;
  localparam logic [2:0] REG_PEN_SETTLE = 3'd5;
  localparam logic [2:0] REG_SEEK_DEL   = 3'd6;
  localparam logic [2:0] REG_REL_DEL    = 3'd7;

  typedef struct packed {
    logic [14:0] max_x;
    logic [14:0] max_y;
    logic [11:0] x_reach;
    logic [11:0] home_lead;
    logic [15:0] motor_off_ticks;
    logic [7:0]  pen_settle_ticks;
    logic [3:0]  home_seek_delay;
    logic [3:0]  home_release_delay;
  } cfg_t;

  // Queue entry: kind, a (16b), b (16b)
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] a;
    logic [15:0] b;
  } qentry_t;

  function automatic logic [7:0] phase_lut(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0:  v = 8'h02;  4'd1:  v = 8'h06;  4'd2:  v = 8'h0a;  4'd3:  v = 8'h09;
      4'd4:  v = 8'h08;  4'd5:  v = 8'h18;  4'd6:  v = 8'h28;  4'd7:  v = 8'h24;
      4'd8:  v = 8'h20;  4'd9:  v = 8'h60;  4'd10: v = 8'ha0;  4'd11: v = 8'h90;
      4'd12: v = 8'h80;  4'd13: v = 8'h81;  4'd14: v = 8'h82;  default: v = 8'h42;
    endcase
    return v;
  endfunction

endpackage

>>> design/slme_cfg.sv
// Configuration register file for the line motion engine.
`timescale 1ns / 1ps
module slme_cfg
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  assign cfg = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_x              <= 15'd32000;
      cfg_r.max_y              <= 15'd4800;
      cfg_r.x_reach            <= 12'd250;
      cfg_r.home_lead          <= 12'd100;
      cfg_r.motor_off_ticks    <= 16'd30000;
      cfg_r.pen_settle_ticks   <= 8'd50;
      cfg_r.home_seek_delay    <= 4'd1;
      cfg_r.home_release_delay <= 4'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_X:      cfg_r.max_x              <= cfg_data[14:0];
        REG_MAX_Y:      cfg_r.max_y              <= cfg_data[14:0];
        REG_X_REACH:    cfg_r.x_reach            <= cfg_data[11:0];
        REG_HOME_LEAD:  cfg_r.home_lead          <= cfg_data[11:0];
        REG_MOTOR_OFF:  cfg_r.motor_off_ticks    <= cfg_data;
        REG_PEN_SETTLE: cfg_r.pen_settle_ticks   <= cfg_data[7:0];
        REG_SEEK_DEL:   cfg_r.home_seek_delay    <= cfg_data[3:0];
        default:        cfg_r.home_release_delay <= cfg_data[3:0];
      endcase
    end
  end

endmodule

>>> design/slme_queue.sv
// Command queue: synchronous memory with prefetched head entry.
`timescale 1ns / 1ps
module slme_queue
  import slme_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  input  logic    pop,
  input  logic    flush,
  output logic    full,
  output logic    empty,
  output qentry_t head
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t mem [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  qentry_t rd_q;
  logic fwd_r;
  qentry_t fwd_data_r;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);

  // Read address is next head so data arrives in time
  always_comb begin
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (flush) begin
      rp_nxt  = wp_r;
      cnt_nxt = '0;
    end else if (pop) begin
      rp_nxt  = inc(rp_r);
      cnt_nxt = cnt_r - 1'b1;
    end else if (push) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
    rd_q       <= mem[rp_nxt];
    fwd_data_r <= push_data;
  end

  // Forward a write to the entry that becomes head next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      fwd_r <= 1'b0;
    end else begin
      if (push) wp_r <= inc(wp_r);
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      fwd_r <= push && (wp_r == rp_nxt);
    end
  end

  assign head = fwd_r ? fwd_data_r : rd_q;

endmodule

>>> design/slme_motion.sv
// Motion core: homing, line stepping, pen control and coil drive.
`timescale 1ns / 1ps
module slme_motion
  import slme_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        go,
  input  logic [2:0]  action,
  input  logic [15:0] x_coord,
  input  logic [15:0] y_coord,
  input  logic        home_switch,
  input  logic        stop_button,
  input  logic        q_full,
  input  logic        q_empty,
  input  qentry_t     q_head,
  output logic        q_push,
  output qentry_t     q_push_data,
  output logic        q_pop,
  output logic        q_flush,
  output logic [7:0]  coil_x,
  output logic [7:0]  coil_y,
  output logic        pen_is_down,
  output logic        speed_strobe,
  output logic [15:0] speed_value,
  output logic        pressure_strobe,
  output logic [15:0] pressure_value,
  output logic        accepted,
  output logic [2:0]  mode
);

  localparam int CB = COORD_BITS;
  localparam int WB = (CB > 17) ? CB + 2 : 19;

  logic signed [CB-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [15:0] org_x_r, org_x_nxt, org_y_r, org_y_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [CB-1:0] lstep_r, lstep_nxt, lsteps_r, lsteps_nxt, lminor_r, lminor_nxt;
  logic signed [CB:0] lerr_r, lerr_nxt;
  logic dirx_r, dirx_nxt, diry_r, diry_nxt, steep_r, steep_nxt;
  logic [7:0]  pause_r, pause_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic        pen_r, pen_nxt;
  logic [15:0] coil_r, coil_nxt;
  logic        sps, prs, acc;
  logic [15:0] spv, prv;

  // Combinational work variables
  logic signed [WB-1:0] tx, ty, lo, dxs, dys;
  logic [WB-1:0] adx, ady;
  logic signed [CB:0] e1;
  logic do_line, pen_chg;

  always_comb begin
    pos_x_nxt = pos_x_r;  pos_y_nxt = pos_y_r;
    org_x_nxt = org_x_r;  org_y_nxt = org_y_r;
    mode_nxt = mode_r;
    lstep_nxt = lstep_r;  lsteps_nxt = lsteps_r;  lminor_nxt = lminor_r;
    lerr_nxt = lerr_r;
    dirx_nxt = dirx_r;  diry_nxt = diry_r;  steep_nxt = steep_r;
    pause_nxt = pause_r;  idle_nxt = idle_r;
    pen_nxt = pen_r;  coil_nxt = coil_r;
    q_push = 1'b0;  q_pop = 1'b0;  q_flush = 1'b0;
    q_push_data = '0;
    sps = 1'b0; prs = 1'b0; spv = '0; prv = '0; acc = 1'b0;
    do_line = 1'b0; pen_chg = 1'b0;
    tx = WB'($signed(x_coord)) + WB'(org_x_r);
    ty = WB'($signed(y_coord)) + WB'(org_y_r);
    lo = (action == ACT_MOVE) ? -WB'(cfg.x_reach) : '0;
    dxs = '0; dys = '0; adx = '0; ady = '0; e1 = '0;

    if (go) begin
      unique case (action)
        ACT_TICK: begin
          if (pause_r != '0) begin
            pause_nxt = pause_r - 1'b1;
          end else begin
            if (stop_button) begin
              mode_nxt = MODE_READY;
              q_flush = 1'b1;
              if (pen_r) pause_nxt = cfg.pen_settle_ticks;
              pen_nxt = 1'b0;
              coil_nxt = '0;
            end
            unique case (mode_nxt)
              MODE_OUT: begin
                if (pos_y_r < 0) pos_y_nxt = pos_y_r + 1'b1;
                else mode_nxt = MODE_SEEK;
              end
              MODE_SEEK: begin
                pause_nxt = 8'(cfg.home_seek_delay);
                if (!home_switch) pos_y_nxt = pos_y_r - 1'b1;
                else mode_nxt = MODE_RELEASE;
              end
              MODE_RELEASE: begin
                pause_nxt = 8'(cfg.home_release_delay);
                if (home_switch) pos_y_nxt = pos_y_r + 1'b1;
                else begin
                  pos_y_nxt = '0;
                  org_x_nxt = '0;
                  org_y_nxt = '0;
                  mode_nxt = MODE_READY;
                end
              end
              MODE_LINE: do_line = 1'b1;
              default: begin
                // Pop next command when the queue holds one
                if (!q_flush && !q_empty) begin
                  q_pop = 1'b1;
                  unique case (q_head.kind)
                    KIND_SPEED: begin sps = 1'b1; spv = q_head.a; end
                    KIND_PRESSURE: begin prs = 1'b1; prv = q_head.a; end
                    default: begin
                      if (q_head.kind == KIND_MOVE) begin
                        if (pen_r) pause_nxt = cfg.pen_settle_ticks;
                        pen_nxt = 1'b0;
                      end else if (!(pos_x_r < 0 || pos_y_r < 0 || pen_r)) begin
                        pen_nxt = 1'b1;
                        pause_nxt = cfg.pen_settle_ticks;
                      end
                      dxs = WB'($signed(q_head.a)) - WB'(pos_x_r);
                      dys = WB'($signed(q_head.b)) - WB'(pos_y_r);
                      if (dxs != '0 || dys != '0) begin
                        dirx_nxt = (dxs > 0);
                        diry_nxt = (dys > 0);
                        adx = (dxs > 0) ? WB'(dxs) : WB'(-dxs);
                        ady = (dys > 0) ? WB'(dys) : WB'(-dys);
                        steep_nxt = !(adx > ady);
                        lsteps_nxt = steep_nxt ? CB'(ady) : CB'(adx);
                        lminor_nxt = steep_nxt ? CB'(adx) : CB'(ady);
                        lstep_nxt = '0;
                        lerr_nxt = (CB+1)'(lsteps_nxt >> 1);
                        mode_nxt = MODE_LINE;
                        do_line = 1'b1;
                      end
                    end
                  endcase
                end
              end
            endcase
            // One Bresenham step
            if (do_line) begin
              if (lstep_nxt >= lsteps_nxt) begin
                mode_nxt = MODE_READY;
              end else begin
                lstep_nxt = lstep_nxt + 1'b1;
                e1 = lerr_nxt - $signed({1'b0, lminor_nxt});
                if (e1 < 0) begin
                  lerr_nxt = e1 + $signed({1'b0, lsteps_nxt});
                  pos_x_nxt = dirx_nxt ? pos_x_r + 1'b1 : pos_x_r - 1'b1;
                  pos_y_nxt = diry_nxt ? pos_y_r + 1'b1 : pos_y_r - 1'b1;
                end else begin
                  lerr_nxt = e1;
                  if (steep_nxt) pos_y_nxt = diry_nxt ? pos_y_r + 1'b1 : pos_y_r - 1'b1;
                  else pos_x_nxt = dirx_nxt ? pos_x_r + 1'b1 : pos_x_r - 1'b1;
                end
                mode_nxt = MODE_LINE;
              end
            end
            // Coil drive or idle timeout
            if (mode_nxt == MODE_READY) begin
              if (idle_r != '0) idle_nxt = idle_r - 1'b1;
              else coil_nxt = '0;
            end else begin
              coil_nxt = {phase_lut(pos_y_nxt[3:0]), phase_lut(pos_x_nxt[3:0])};
              idle_nxt = cfg.motor_off_ticks;
            end
          end
        end
        ACT_MOVE, ACT_DRAW: begin
          // Signed compares: a move may reach into negative x
          if (!q_full && tx >= lo && tx <= $signed(WB'(cfg.max_x)) && ty >= 0
              && ty <= $signed(WB'(cfg.max_y))) begin
            q_push = 1'b1;
            q_push_data.kind = (action == ACT_MOVE) ? KIND_MOVE : KIND_DRAW;
            q_push_data.a = tx[15:0];
            q_push_data.b = ty[15:0];
            acc = 1'b1;
          end
        end
        ACT_SPEED, ACT_PRESSURE: begin
          if (!q_full) begin
            q_push = 1'b1;
            q_push_data.kind = (action == ACT_SPEED) ? KIND_SPEED : KIND_PRESSURE;
            q_push_data.a = x_coord;
            acc = 1'b1;
          end
        end
        ACT_HOME: begin
          if (q_empty) begin
            if (pen_r) pause_nxt = cfg.pen_settle_ticks;
            pen_nxt = 1'b0;
            pos_y_nxt = -CB'(cfg.home_lead);
            pos_x_nxt = -CB'(cfg.x_reach);
            mode_nxt = MODE_OUT;
            acc = 1'b1;
          end
        end
        ACT_ORIGIN: begin
          if (q_empty && pos_x_r >= 0 && pos_y_r >= 0) begin
            org_x_nxt = 16'(pos_x_r);
            org_y_nxt = 16'(pos_y_r);
            acc = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= -CB'(12'd250);
      pos_y_r <= -CB'(12'd100);
      org_x_r <= '0;  org_y_r <= '0;
      mode_r <= MODE_OUT;
      lstep_r <= '0;  lsteps_r <= '0;  lminor_r <= '0;  lerr_r <= '0;
      dirx_r <= 1'b0;  diry_r <= 1'b0;  steep_r <= 1'b0;
      pause_r <= '0;  idle_r <= 16'd30000;
      pen_r <= 1'b0;  coil_r <= '0;
    end else begin
      pos_x_r <= pos_x_nxt;  pos_y_r <= pos_y_nxt;
      org_x_r <= org_x_nxt;  org_y_r <= org_y_nxt;
      mode_r <= mode_nxt;
      lstep_r <= lstep_nxt;  lsteps_r <= lsteps_nxt;  lminor_r <= lminor_nxt;
      lerr_r <= lerr_nxt;
      dirx_r <= dirx_nxt;  diry_r <= diry_nxt;  steep_r <= steep_nxt;
      pause_r <= pause_nxt;  idle_r <= idle_nxt;
      pen_r <= pen_nxt;  coil_r <= coil_nxt;
    end
  end

  // Result fields, registered by the caller
  assign coil_x = coil_nxt[7:0];
  assign coil_y = coil_nxt[15:8];
  assign pen_is_down = pen_nxt;
  assign speed_strobe = sps;
  assign speed_value = spv;
  assign pressure_strobe = prs;
  assign pressure_value = prv;
  assign accepted = acc;
  assign mode = mode_nxt;

endmodule

>>> design/stepper_line_motion_engine_core.sv
// Top level of the two-axis stepper line motion engine.
// Usage:
//  - Input stream carries one command or tick per transaction; a tick runs
//    pause, stop abort, homing or command pop and one Bresenham step.
//  - Output stream returns one result per input transaction: coil drives,
//    pen level, speed/pressure strobes, accepted flag and engine mode.
//  - The result of an accepted input is valid in the cycle after acceptance.
//  - Throughput is one item per cycle while the receiver takes results; the
//    command memory read is registered, covered by prefetching the head entry and forwarding a fresh push.
//  - A single output register holds the result; in_tready is high when it
//    is empty or being taken, so a stalled receiver stalls the input.
//  - Reset (rst_n low, synchronous) restores register defaults, the
//    homing start position and an empty queue; no clearing pass is needed.
//  - Config writes via cfg_we/cfg_index/cfg_data only while idle.
`timescale 1ns / 1ps
module stepper_line_motion_engine_core
  import slme_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int COORD_BITS  = CoordBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: action[2:0], x_coord[18:3], y_coord[34:19], home_switch[35], stop_button[36]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: coil_x[7:0], coil_y[15:8], pen_is_down[16], speed_strobe[17],
  // speed_value[33:18], pressure_strobe[34], pressure_value[50:35],
  // accepted[51], mode[54:52]
  output logic [55:0] out_tdata
);

  cfg_t cfg;
  logic go, q_full, q_empty, q_push, q_pop, q_flush;
  qentry_t q_head, q_push_data;
  logic [7:0] cx, cy;
  logic pd, ss, ps, ac;
  logic [15:0] sv, pv;
  logic [2:0] md;
  logic vld_r;
  logic [55:0] res_r;

  assign in_tready = !vld_r || out_tready;
  assign go = in_tvalid && in_tready;

  slme_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  slme_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_push_data),
    .pop(q_pop), .flush(q_flush), .full(q_full), .empty(q_empty), .head(q_head)
  );

  slme_motion #(.COORD_BITS(COORD_BITS)) u_motion (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .go(go),
    .action(in_tdata[2:0]), .x_coord(in_tdata[18:3]), .y_coord(in_tdata[34:19]),
    .home_switch(in_tdata[35]), .stop_button(in_tdata[36]),
    .q_full(q_full), .q_empty(q_empty), .q_head(q_head),
    .q_push(q_push), .q_push_data(q_push_data), .q_pop(q_pop), .q_flush(q_flush),
    .coil_x(cx), .coil_y(cy), .pen_is_down(pd), .speed_strobe(ss),
    .speed_value(sv), .pressure_strobe(ps), .pressure_value(pv),
    .accepted(ac), .mode(md)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (in_tready) vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (go) res_r <= {1'b0, md, ac, pv, ps, sv, ss, pd, cy, cx};
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = res_r;

endmodule

>>> verif/motion_checker.sv
// Checker: predicts the line motion engine from its input stream and compares results.
`timescale 1ns / 1ps
module motion_checker
  import slme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // tdata: action, x_coord, y_coord, home_switch, stop_button
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // tdata: coil_x, coil_y, pen_is_down, speed_strobe, speed_value,
  // pressure_strobe, pressure_value, accepted, mode
  input  logic [55:0] out_tdata,
  output int          fault_count,
  output int          pending
);

  typedef struct packed {
    logic        pad;
    logic [2:0]  mode;
    logic        acc;
    logic [15:0] pval;
    logic        pstb;
    logic [15:0] sval;
    logic        sstb;
    logic        pen;
    logic [7:0]  cy;
    logic [7:0]  cx;
  } drive_word_t;

  typedef struct {
    logic [1:0] kind;
    int         a;
    int         b;
  } job_t;

  localparam int JobDepth = 32;

  // register copies
  int lim_x, lim_y, x_reach, home_lead, motor_off, pen_settle, seek_del, rel_del;

  // engine state
  int          pos_x, pos_y, org_x, org_y;
  logic [2:0]  eng_mode;
  int          ln_pos, ln_len, ln_minor, ln_err, dir_x, dir_y;
  bit          steep;
  int          pause_left, idle_left;
  logic        pen_lvl;
  logic [15:0] coils;
  job_t        jobs[$];
  drive_word_t expected_drives[$];

  assign pending = expected_drives.size();

  function automatic int wrap17(int v);
    logic [16:0] u;
    u = v[16:0];
    return int'($signed(u));
  endfunction

  task automatic pen_up();
    if (pen_lvl) pause_left = pen_settle;
    pen_lvl = 1'b0;
  endtask

  task automatic pen_lower();
    if (pos_x < 0 || pos_y < 0 || pen_lvl) return;
    pen_lvl    = 1'b1;
    pause_left = pen_settle;
  endtask

  task automatic start_line(int tx, int ty);
    int dx, dy;
    if (tx > pos_x) begin dir_x = 1;  dx = tx - pos_x; end
    else            begin dir_x = -1; dx = pos_x - tx; end
    if (ty > pos_y) begin dir_y = 1;  dy = ty - pos_y; end
    else            begin dir_y = -1; dy = pos_y - ty; end
    if (dx > dy) begin steep = 0; ln_len = dx; ln_minor = dy; end
    else         begin steep = 1; ln_len = dy; ln_minor = dx; end
    ln_pos = 0;
    ln_err = ln_len / 2;
  endtask

  // one Bresenham step; returns the next mode
  function automatic logic [2:0] line_step();
    if (ln_pos >= ln_len) return MODE_READY;
    ln_pos++;
    ln_err -= ln_minor;
    if (ln_err < 0) begin
      ln_err += ln_len;
      pos_x = wrap17(pos_x + dir_x);
      pos_y = wrap17(pos_y + dir_y);
    end else if (steep) begin
      pos_y = wrap17(pos_y + dir_y);
    end else begin
      pos_x = wrap17(pos_x + dir_x);
    end
    return MODE_LINE;
  endfunction

  task automatic pop_job(inout drive_word_t r);
    job_t j;
    if (jobs.size() == 0) begin
      eng_mode = MODE_READY;
      return;
    end
    j = jobs.pop_front();
    eng_mode = MODE_READY;
    case (j.kind)
      KIND_MOVE, KIND_DRAW: begin
        if (j.kind == KIND_MOVE) pen_up();
        else pen_lower();
        if (!(pos_x == j.a && pos_y == j.b)) begin
          start_line(j.a, j.b);
          eng_mode = line_step();
        end
      end
      KIND_SPEED: begin
        r.sstb = 1'b1;
        r.sval = j.a[15:0];
      end
      default: begin
        r.pstb = 1'b1;
        r.pval = j.a[15:0];
      end
    endcase
  endtask

  task automatic run_tick(logic sw, logic stop, inout drive_word_t r);
    if (pause_left != 0) begin
      pause_left--;
      return;
    end
    if (stop) begin
      eng_mode = MODE_READY;
      jobs.delete();
      pen_up();
      coils = '0;
    end
    case (eng_mode)
      MODE_OUT: begin
        if (pos_y < 0) pos_y = wrap17(pos_y + 1);
        else eng_mode = MODE_SEEK;
      end
      MODE_SEEK: begin
        pause_left = seek_del;
        if (!sw) pos_y = wrap17(pos_y - 1);
        else eng_mode = MODE_RELEASE;
      end
      MODE_RELEASE: begin
        pause_left = rel_del;
        if (sw) pos_y = wrap17(pos_y + 1);
        else begin
          pos_y = 0;
          org_x = 0;
          org_y = 0;
          eng_mode = MODE_READY;
        end
      end
      MODE_LINE: eng_mode = line_step();
      default: pop_job(r);
    endcase
    if (eng_mode == MODE_READY) begin
      if (idle_left != 0) idle_left--;
      else coils = '0;
    end else begin
      coils = {phase_lut(pos_y[3:0]), phase_lut(pos_x[3:0])};
      idle_left = motor_off;
    end
  endtask

  task automatic predict_item(logic [39:0] d, output drive_word_t r);
    logic [2:0] act;
    int xv, yv, tx, ty, lo;
    job_t j;
    act = d[2:0];
    xv  = int'($signed(d[18:3]));
    yv  = int'($signed(d[34:19]));
    r   = '0;
    case (act)
      ACT_TICK: run_tick(d[35], d[36], r);
      ACT_MOVE, ACT_DRAW: begin
        tx = xv + org_x;
        ty = yv + org_y;
        lo = (act == ACT_MOVE) ? -x_reach : 0;
        if (jobs.size() < JobDepth && tx >= lo && tx <= lim_x && ty >= 0 && ty <= lim_y) begin
          j.kind = (act == ACT_MOVE) ? KIND_MOVE : KIND_DRAW;
          j.a = tx;
          j.b = ty;
          jobs.push_back(j);
          r.acc = 1'b1;
        end
      end
      ACT_SPEED, ACT_PRESSURE: begin
        if (jobs.size() < JobDepth) begin
          j.kind = (act == ACT_SPEED) ? KIND_SPEED : KIND_PRESSURE;
          j.a = xv;
          j.b = 0;
          jobs.push_back(j);
          r.acc = 1'b1;
        end
      end
      ACT_HOME: begin
        if (jobs.size() == 0) begin
          pen_up();
          pos_y = wrap17(-home_lead);
          pos_x = wrap17(-x_reach);
          eng_mode = MODE_OUT;
          r.acc = 1'b1;
        end
      end
      ACT_ORIGIN: begin
        if (jobs.size() == 0 && pos_x >= 0 && pos_y >= 0) begin
          org_x = pos_x & 16'hffff;
          org_y = pos_y & 16'hffff;
          r.acc = 1'b1;
        end
      end
      default: ;
    endcase
    r.cx   = coils[7:0];
    r.cy   = coils[15:8];
    r.pen  = pen_lvl;
    r.mode = eng_mode;
  endtask

  always @(posedge clk) begin
    drive_word_t want, got;
    if (!rst_n) begin
      lim_x = 32000; lim_y = 4800; x_reach = 250; home_lead = 100;
      motor_off = 30000; pen_settle = 50; seek_del = 1; rel_del = 4;
      pos_x = -250; pos_y = -100; org_x = 0; org_y = 0;
      eng_mode = MODE_OUT;
      ln_pos = 0; ln_len = 0; ln_minor = 0; ln_err = 0; dir_x = 0; dir_y = 0; steep = 0;
      pause_left = 0; idle_left = 30000; pen_lvl = 1'b0; coils = '0;
      jobs.delete();
      expected_drives.delete();
      fault_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_X:      lim_x = cfg_data[14:0];
          REG_MAX_Y:      lim_y = cfg_data[14:0];
          REG_X_REACH:    x_reach = cfg_data[11:0];
          REG_HOME_LEAD:  home_lead = cfg_data[11:0];
          REG_MOTOR_OFF:  motor_off = cfg_data;
          REG_PEN_SETTLE: pen_settle = cfg_data[7:0];
          REG_SEEK_DEL:   seek_del = cfg_data[3:0];
          default:        rel_del = cfg_data[3:0];
        endcase
      end
      // compare first: a result leaving now belongs to an older transaction
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_drives.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_drives.pop_front();
          if (got.cx != want.cx || got.cy != want.cy || got.pen != want.pen ||
              got.sstb != want.sstb || got.sval != want.sval ||
              got.pstb != want.pstb || got.pval != want.pval ||
              got.acc != want.acc || got.mode != want.mode) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"mismatch: exp cx=%h cy=%h pen=%b spd=%b/%h prs=%b/%h acc=%b mode=%0d",
                        " | got cx=%h cy=%h pen=%b spd=%b/%h prs=%b/%h acc=%b mode=%0d"},
                       want.cx, want.cy, want.pen, want.sstb, want.sval, want.pstb,
                       want.pval, want.acc, want.mode, got.cx, got.cy, got.pen,
                       got.sstb, got.sval, got.pstb, got.pval, got.acc, got.mode);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_item(in_tdata, want);
        expected_drives.push_back(want);
      end
    end
  end

endmodule

>>> verif/stepper_line_motion_engine_core_test.sv
// Testbench top: stimulus, configuration phases and verdict for the line motion engine.
`timescale 1ns / 1ps
module stepper_line_motion_engine_core_test;
  import slme_pkg::*;

  localparam int StallLimit = 20000;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  int          fault_count, pending;
  int          sent = 0, taken = 0, quiet_cycles = 0;
  bit          steady = 0;
  logic [2:0]  seen_mode = MODE_OUT;

  stepper_line_motion_engine_core dut (.*);

  motion_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  // receiver stalls about a third of the time, never in the steady phase
  always @(posedge clk) out_tready <= steady || ($urandom_range(99) >= 33);

  // transaction counters, last reported mode, stall watchdog
  always @(posedge clk) begin
    if (in_tvalid && in_tready) sent <= sent + 1;
    if (out_tvalid && out_tready) begin
      taken <= taken + 1;
      seen_mode <= out_tdata[54:52];
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("stepper_line_motion_engine_core_test: errors");
      $finish;
    end
  end

  function automatic logic rbit();
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [15:0] r16();
    return 16'($urandom_range(65535));
  endfunction

  task automatic send(logic [2:0] act, logic [15:0] x, logic [15:0] y, logic sw, logic stop);
    bit ready_now;
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, stop, sw, y, x, act};
    do begin
      @(negedge clk);
      ready_now = in_tready;
      @(posedge clk);
    end while (!ready_now);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (taken != sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(int mx, int my, int me, int hl, int mo, int ps, int sd, int rd);
    int vals[8];
    vals = '{mx, my, me, hl, mo, ps, sd, rd};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i][15:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // small coordinates mostly, full range sometimes
  function automatic logic [15:0] pick_coord();
    int v;
    if ($urandom_range(99) < 80) begin
      v = int'($urandom_range(48)) - 8;
      return v[15:0];
    end
    return r16();
  endfunction

  task automatic tick_item();
    logic sw;
    if (seen_mode == MODE_SEEK) sw = ($urandom_range(99) < 15);
    else if (seen_mode == MODE_RELEASE) sw = ($urandom_range(99) < 60);
    else sw = rbit();
    send(ACT_TICK, r16(), r16(), sw, $urandom_range(99) < 2);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) tick_item();
    else if (r < 67) send(ACT_MOVE, pick_coord(), pick_coord(), rbit(), rbit());
    else if (r < 79) send(ACT_DRAW, pick_coord(), pick_coord(), rbit(), rbit());
    else if (r < 84) send(ACT_SPEED, r16(), r16(), 1'b0, 1'b0);
    else if (r < 89) send(ACT_PRESSURE, r16(), r16(), 1'b0, 1'b0);
    else if (r < 92) send(ACT_HOME, r16(), r16(), 1'b0, 1'b0);
    else if (r < 96) send(ACT_ORIGIN, r16(), r16(), 1'b0, 1'b0);
    else if (r < 98) send(ACT_UNUSED, r16(), r16(), 1'b1, 1'b1);
    else begin
      // burst that fills the command queue
      for (int k = 0; k < 34; k++)
        send(rbit() ? ACT_SPEED : ACT_PRESSURE, r16(), 16'd0, 1'b0, 1'b0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: refusals while homing, range edges, every action, stop abort
    send(ACT_ORIGIN, 16'd0, 16'd0, 1'b0, 1'b0);
    send(ACT_MOVE, 16'h8000, 16'h8000, 1'b0, 1'b0);
    send(ACT_MOVE, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
    send(ACT_MOVE, 16'd10, 16'd10, 1'b0, 1'b0);
    send(ACT_DRAW, 16'd20, 16'd5, 1'b0, 1'b0);
    send(ACT_DRAW, 16'hffff, 16'd0, 1'b0, 1'b0);
    send(ACT_MOVE, -16'sd250, 16'd0, 1'b0, 1'b0);
    send(ACT_MOVE, 16'd32000, 16'd4800, 1'b0, 1'b0);
    send(ACT_SPEED, 16'h7fff, 16'd0, 1'b0, 1'b0);
    send(ACT_SPEED, 16'h8000, 16'd0, 1'b0, 1'b0);
    send(ACT_PRESSURE, 16'd0, 16'd0, 1'b0, 1'b0);
    send(ACT_PRESSURE, 16'hffff, 16'd0, 1'b0, 1'b0);
    send(ACT_HOME, 16'd0, 16'd0, 1'b0, 1'b0);
    send(ACT_UNUSED, 16'hffff, 16'hffff, 1'b1, 1'b1);
    send(ACT_TICK, 16'hffff, 16'hffff, 1'b1, 1'b0);
    send(ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b1);
    send(ACT_HOME, 16'd0, 16'd0, 1'b0, 1'b0);
    send(ACT_TICK, 16'h5a5a, 16'ha5a5, 1'b0, 1'b0);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: write_regs(32767, 32767, 0, 0, 0, 0, 0, 0);
          2: write_regs(0, 0, 4095, 8, 65535, 255, 15, 15);
          3: write_regs(200, 150, 20, 3, 5, 2, 1, 2);
          default: write_regs(1000, 1000, 5, 10, 40, 6, 0, 4);
        endcase
        steady = (p == 3);
        send(ACT_TICK, 16'd0, 16'd0, 1'b0, 1'b1);
        send(ACT_HOME, 16'd0, 16'd0, 1'b0, 1'b0);
      end
      for (int n = 0; n < 50; n++) random_item();
    end

    drain();
    repeat (5) @(posedge clk);
    if (fault_count == 0 && pending == 0) begin
      $display("stepper_line_motion_engine_core_test: clean");
    end else begin
      $display("stepper_line_motion_engine_core_test: errors");
    end
    $finish;
  end

endmodule
